>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, clocked on i_clk, off during reset
`define SDI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdi assertion failed");
// next-cycle implication
`define SDI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdi assertion failed");
`endif

>>> hw/rtl/sdi_pkg.sv
// Types, codes and helper functions of the SD card init and block sequencer.
package sdi_pkg;

    localparam int unsigned DivMax  = 1023;
    localparam int          DivW    = 10;
    localparam int          WaitW   = 20;
    localparam int          BlkShift = 9;   // 512-byte blocks

    // phases
    localparam logic [4:0] P_IDLE       = 5'd0;
    localparam logic [4:0] P_HOST_RESET = 5'd1;
    localparam logic [4:0] P_CLK_ID     = 5'd2;
    localparam logic [4:0] P_SETTLE     = 5'd3;
    localparam logic [4:0] P_CMD0       = 5'd4;
    localparam logic [4:0] P_CMD8       = 5'd5;
    localparam logic [4:0] P_CMD55      = 5'd6;
    localparam logic [4:0] P_ACMD41     = 5'd7;
    localparam logic [4:0] P_RETRY      = 5'd8;
    localparam logic [4:0] P_CMD2       = 5'd9;
    localparam logic [4:0] P_CMD3       = 5'd10;
    localparam logic [4:0] P_CLK_DATA   = 5'd11;
    localparam logic [4:0] P_CMD7       = 5'd12;
    localparam logic [4:0] P_CMD16      = 5'd13;
    localparam logic [4:0] P_READY      = 5'd14;
    localparam logic [4:0] P_XCMD       = 5'd15;
    localparam logic [4:0] P_XRDY       = 5'd16;
    localparam logic [4:0] P_XDONE      = 5'd17;

    // events
    localparam logic [3:0] E_TICK       = 4'd0;
    localparam logic [3:0] E_START_INIT = 4'd1;
    localparam logic [3:0] E_START_XFER = 4'd2;
    localparam logic [3:0] E_CMD_DONE   = 4'd3;
    localparam logic [3:0] E_CMD_ERROR  = 4'd4;
    localparam logic [3:0] E_CLK_STABLE = 4'd5;
    localparam logic [3:0] E_DATA_READY = 4'd6;
    localparam logic [3:0] E_DATA_DONE  = 4'd7;
    localparam logic [3:0] E_RESET_DONE = 4'd8;

    // actions
    localparam logic [3:0] A_NONE       = 4'd0;
    localparam logic [3:0] A_RESET_HOST = 4'd1;
    localparam logic [3:0] A_SET_CLOCK  = 4'd2;
    localparam logic [3:0] A_POWER_ON   = 4'd3;
    localparam logic [3:0] A_ISSUE      = 4'd4;
    localparam logic [3:0] A_RESET_CMD  = 4'd5;
    localparam logic [3:0] A_MOVE       = 4'd6;
    localparam logic [3:0] A_OK         = 4'd7;
    localparam logic [3:0] A_FAILED     = 4'd8;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_ALL_CID  = 6'd2;
    localparam logic [5:0] CMD_REL_ADDR = 6'd3;
    localparam logic [5:0] CMD_SELECT   = 6'd7;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_READ     = 6'd17;
    localparam logic [5:0] CMD_WRITE    = 6'd24;
    localparam logic [5:0] ACMD_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP      = 6'd55;

    // response kinds
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_136  = 2'd1;
    localparam logic [1:0] K_48   = 2'd2;
    localparam logic [1:0] K_48B  = 2'd3;

    // argument sources
    localparam logic [2:0] ARG_ZERO    = 3'd0;
    localparam logic [2:0] ARG_IF_COND = 3'd1;
    localparam logic [2:0] ARG_OP_COND = 3'd2;
    localparam logic [2:0] ARG_BLKLEN  = 3'd3;
    localparam logic [2:0] ARG_RCA     = 3'd4;
    localparam logic [2:0] ARG_BLK     = 3'd5;

    localparam logic [31:0] IfCondArg = 32'h0000_01AA;
    localparam logic [31:0] OpCondArg = 32'h51FF_8000;
    localparam logic [31:0] BlkLenArg = 32'd512;

    // wait timer operations
    localparam logic [2:0] WT_NONE   = 3'd0;
    localparam logic [2:0] WT_EVENT  = 3'd1;
    localparam logic [2:0] WT_CLOCK  = 3'd2;
    localparam logic [2:0] WT_RETRY  = 3'd3;
    localparam logic [2:0] WT_SETTLE = 3'd4;
    localparam logic [2:0] WT_DEC    = 3'd5;

    // op-cond timer operations
    localparam logic [1:0] OC_NONE  = 2'd0;
    localparam logic [1:0] OC_CLEAR = 2'd1;
    localparam logic [1:0] OC_INC   = 2'd2;

    // config register indexes
    localparam logic [2:0] CFG_BASE     = 3'd0;
    localparam logic [2:0] CFG_ID_CLK   = 3'd1;
    localparam logic [2:0] CFG_DATA_CLK = 3'd2;
    localparam logic [2:0] CFG_EVT_TO   = 3'd3;
    localparam logic [2:0] CFG_CLK_TO   = 3'd4;
    localparam logic [2:0] CFG_OC_TO    = 3'd5;
    localparam logic [2:0] CFG_RETRY    = 3'd6;
    localparam logic [2:0] CFG_SETTLE   = 3'd7;

    typedef struct packed {
        logic [3:0] action;
        logic [5:0] cmd_index;
        logic [1:0] resp_kind;
        logic       crc;
        logic       dat;
        logic       dir_c2h;   // card_to_host = !dir_write
        logic [2:0] arg_sel;
        logic       use_div;
    } t_res;

    typedef struct packed {
        logic       latch_in;
        logic [2:0] wt_op;
        logic [1:0] oc_op;
        logic       clr_card;
        logic       set_sdhc;
        logic       set_rca;
        logic       load_xfer;
        logic       adv_block;
        logic       div_start;
        logic       div_sel;   // 1: data clock target
        logic       out_load;
        logic       out_last;
        t_res       res;
    } t_cmd;

    typedef struct packed {
        logic [3:0] req_type;
        logic       card_present;
        logic       require_card;
        logic       resp_ready;
        logic       blk_zero;
        logic       wt_zero;
        logic       wt_le1;
        logic       oc_over;
        logic       retry_zero;
        logic       settle_zero;
        logic       blocks_one;
        logic       div_busy;
        logic       out_busy;
    } t_sts;

    function automatic t_res f_act(input logic [3:0] act);
        t_res r;
        r           = '0;
        r.action    = act;
        r.use_div   = (act == A_SET_CLOCK);
        r.dir_c2h   = (act == A_MOVE);
        return r;
    endfunction

    function automatic t_res f_cmd(input logic [5:0] idx, input logic [1:0] kind,
                                   input logic crc, input logic dat,
                                   input logic c2h, input logic [2:0] asel);
        t_res r;
        r           = '0;
        r.action    = A_ISSUE;
        r.cmd_index = idx;
        r.resp_kind = kind;
        r.crc       = crc;
        r.dat       = dat;
        r.dir_c2h   = c2h;
        r.arg_sel   = asel;
        return r;
    endfunction

endpackage

>>> hw/rtl/sdi_in_if.sv
// Request channel: one event per beat.
interface sdi_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  req_type;
    logic [31:0] resp_word;
    logic        card_present;
    logic        require_card;
    logic [31:0] start_lba;
    logic [15:0] block_count;
    logic        write_not_read;

    modport source (output valid, req_type, resp_word, card_present, require_card,
                    start_lba, block_count, write_not_read, input ready);
    modport sink   (input valid, req_type, resp_word, card_present, require_card,
                    start_lba, block_count, write_not_read, output ready);
endinterface

>>> hw/rtl/sdi_out_if.sv
// Result channel: one host action per beat.
interface sdi_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [5:0]  cmd_index;
    logic [1:0]  resp_kind;
    logic        crc_check;
    logic        data_cmd;
    logic        card_to_host;
    logic [31:0] cmd_arg;
    logic [9:0]  clock_div;
    logic        card_is_sdhc;
    logic [15:0] card_rca;
    logic        last;

    modport source (output valid, action, cmd_index, resp_kind, crc_check, data_cmd,
                    card_to_host, cmd_arg, clock_div, card_is_sdhc, card_rca, last,
                    input ready);
    modport sink   (input valid, action, cmd_index, resp_kind, crc_check, data_cmd,
                    card_to_host, cmd_arg, clock_div, card_is_sdhc, card_rca, last,
                    output ready);
endinterface

>>> hw/rtl/sdi_clkdiv.sv
// Iterative clock divider search, one candidate per cycle.
module sdi_clkdiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_base,
    input  logic [31:0] i_target,
    output logic        o_busy,
    output logic [sdi_pkg::DivW-1:0] o_div
);
    localparam int StepW = 34;
    localparam int AccW  = StepW + sdi_pkg::DivW;

    logic                    r_busy, n_busy;
    logic [sdi_pkg::DivW-1:0] r_div, n_div;
    logic [AccW-1:0]         r_acc, n_acc;
    logic [StepW-1:0]        r_step, n_step;
    logic [StepW-1:0]        w_step0;

    // base/(2d) > f  <=>  base >= 2d(f+1); acc holds 2d(f+1)
    assign w_step0 = ({2'b00, i_target} + StepW'(1)) << 1;

    always_comb begin
        n_busy = r_busy;
        n_div  = r_div;
        n_acc  = r_acc;
        n_step = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_div  = sdi_pkg::DivW'(1);
            n_step = w_step0;
            n_acc  = AccW'(w_step0);
        end else if (r_busy) begin
            if ((AccW'(i_base) >= r_acc) &&
                (r_div < sdi_pkg::DivW'(sdi_pkg::DivMax))) begin
                n_div = r_div + sdi_pkg::DivW'(1);
                n_acc = r_acc + AccW'(r_step);
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_div  <= n_div;
        r_acc  <= n_acc;
        r_step <= n_step;
    end

    assign o_busy = r_busy;
    assign o_div  = r_div;
endmodule

>>> hw/rtl/sdi_dpath.sv
// Datapath: config registers, timers, card data, divider and result register.
module sdi_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  sdi_pkg::t_cmd i_cmd,
    output sdi_pkg::t_sts o_sts,
    sdi_in_if.sink        i_req,
    sdi_out_if.source     o_res
);
    localparam int WW = sdi_pkg::WaitW;

    logic [31:0] r_base, r_id_clk, r_data_clk;
    logic [WW-1:0] r_evt_to, r_clk_to, r_oc_to, r_retry, r_settle;

    logic [3:0]  r_req_type;
    logic [31:0] r_resp;
    logic        r_present, r_require, r_wnr;
    logic [31:0] r_lba_in;
    logic [15:0] r_cnt_in;

    logic [WW-1:0] r_wt, r_oc;
    logic          r_sdhc, r_dir;
    logic [15:0]   r_rca, r_blocks;
    logic [31:0]   r_lba;

    logic        r_out_valid;
    logic [3:0]  r_action;
    logic [5:0]  r_cmd_index;
    logic [1:0]  r_resp_kind;
    logic        r_crc, r_dat, r_c2h, r_out_sdhc, r_last;
    logic [31:0] r_arg;
    logic [9:0]  r_clock_div;
    logic [15:0] r_out_rca;

    logic        w_div_busy;
    logic [sdi_pkg::DivW-1:0] w_div;
    logic [31:0] w_arg;

    sdi_clkdiv u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_base   (r_base),
        .i_target (i_cmd.div_sel ? r_data_clk : r_id_clk),
        .o_busy   (w_div_busy),
        .o_div    (w_div)
    );

    always_comb begin
        unique case (i_cmd.res.arg_sel)
            sdi_pkg::ARG_IF_COND: w_arg = sdi_pkg::IfCondArg;
            sdi_pkg::ARG_OP_COND: w_arg = sdi_pkg::OpCondArg;
            sdi_pkg::ARG_BLKLEN:  w_arg = sdi_pkg::BlkLenArg;
            sdi_pkg::ARG_RCA:     w_arg = {r_rca, 16'h0000};
            sdi_pkg::ARG_BLK:     w_arg = r_sdhc ? r_lba : (r_lba << sdi_pkg::BlkShift);
            default:              w_arg = 32'h0;
        endcase
    end

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= 32'd41666666;
            r_id_clk   <= 32'd400000;
            r_data_clk <= 32'd25000000;
            r_evt_to   <= WW'(300000);
            r_clk_to   <= WW'(500000);
            r_oc_to    <= WW'(1000000);
            r_retry    <= WW'(10000);
            r_settle   <= WW'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdi_pkg::CFG_BASE:     r_base     <= i_cfg_data;
                sdi_pkg::CFG_ID_CLK:   r_id_clk   <= i_cfg_data;
                sdi_pkg::CFG_DATA_CLK: r_data_clk <= i_cfg_data;
                sdi_pkg::CFG_EVT_TO:   r_evt_to   <= i_cfg_data[WW-1:0];
                sdi_pkg::CFG_CLK_TO:   r_clk_to   <= i_cfg_data[WW-1:0];
                sdi_pkg::CFG_OC_TO:    r_oc_to    <= i_cfg_data[WW-1:0];
                sdi_pkg::CFG_RETRY:    r_retry    <= i_cfg_data[WW-1:0];
                sdi_pkg::CFG_SETTLE:   r_settle   <= i_cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    // input beat latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_req_type <= i_req.req_type;
            r_resp     <= i_req.resp_word;
            r_present  <= i_req.card_present;
            r_require  <= i_req.require_card;
            r_lba_in   <= i_req.start_lba;
            r_cnt_in   <= i_req.block_count;
            r_wnr      <= i_req.write_not_read;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt     <= '0;
            r_oc     <= '0;
            r_sdhc   <= 1'b0;
            r_rca    <= '0;
            r_lba    <= '0;
            r_blocks <= '0;
            r_dir    <= 1'b0;
        end else begin
            unique case (i_cmd.wt_op)
                sdi_pkg::WT_EVENT:  r_wt <= r_evt_to;
                sdi_pkg::WT_CLOCK:  r_wt <= r_clk_to;
                sdi_pkg::WT_RETRY:  r_wt <= r_retry;
                sdi_pkg::WT_SETTLE: r_wt <= r_settle;
                sdi_pkg::WT_DEC:    r_wt <= r_wt - WW'(1);
                default: ;
            endcase
            unique case (i_cmd.oc_op)
                sdi_pkg::OC_CLEAR: r_oc <= '0;
                sdi_pkg::OC_INC:   if (r_oc != '1) r_oc <= r_oc + WW'(1);
                default: ;
            endcase
            if (i_cmd.clr_card) begin
                r_sdhc   <= 1'b0;
                r_rca    <= '0;
                r_blocks <= '0;
            end
            if (i_cmd.set_sdhc) r_sdhc <= r_resp[30];
            if (i_cmd.set_rca)  r_rca  <= r_resp[31:16];
            if (i_cmd.load_xfer) begin
                r_lba    <= r_lba_in;
                r_blocks <= r_cnt_in;
                r_dir    <= r_wnr;
            end
            if (i_cmd.adv_block) begin
                r_lba    <= r_lba + 32'd1;
                r_blocks <= r_blocks - 16'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_action    <= i_cmd.res.action;
            r_cmd_index <= (i_cmd.res.arg_sel == sdi_pkg::ARG_BLK && r_dir) ?
                           sdi_pkg::CMD_WRITE : i_cmd.res.cmd_index;
            r_resp_kind <= i_cmd.res.resp_kind;
            r_crc       <= i_cmd.res.crc;
            r_dat       <= i_cmd.res.dat;
            r_c2h       <= i_cmd.res.dir_c2h & ~r_dir;
            r_arg       <= w_arg;
            r_clock_div <= i_cmd.res.use_div ? 10'(w_div) : 10'd0;
            r_out_sdhc  <= r_sdhc;
            r_out_rca   <= r_rca;
            r_last      <= i_cmd.out_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.action       = r_action;
    assign o_res.cmd_index    = r_cmd_index;
    assign o_res.resp_kind    = r_resp_kind;
    assign o_res.crc_check    = r_crc;
    assign o_res.data_cmd     = r_dat;
    assign o_res.card_to_host = r_c2h;
    assign o_res.cmd_arg      = r_arg;
    assign o_res.clock_div    = r_clock_div;
    assign o_res.card_is_sdhc = r_out_sdhc;
    assign o_res.card_rca     = r_out_rca;
    assign o_res.last         = r_last;

    assign o_sts.req_type     = r_req_type;
    assign o_sts.card_present = r_present;
    assign o_sts.require_card = r_require;
    assign o_sts.resp_ready   = r_resp[31];
    assign o_sts.blk_zero     = (r_cnt_in == 16'd0);
    assign o_sts.wt_zero      = (r_wt == '0);
    assign o_sts.wt_le1       = (r_wt <= WW'(1));
    assign o_sts.oc_over      = (r_oc > r_oc_to);
    assign o_sts.retry_zero   = (r_retry == '0);
    assign o_sts.settle_zero  = (r_settle == '0);
    assign o_sts.blocks_one   = (r_blocks == 16'd1);
    assign o_sts.div_busy     = w_div_busy;
    assign o_sts.out_busy     = r_out_valid & ~o_res.ready;
endmodule

>>> hw/rtl/sdi_ctrl.sv
// Controller: card phase machine and per-beat sequencing of results.
module sdi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  sdi_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output sdi_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT0 = 3'd3;
    localparam logic [2:0] S_OUT1 = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [4:0]    r_phase, n_phase;
    sdi_pkg::t_res r_res0, n_res0, r_res1, n_res1;
    logic          r_two, n_two;
    logic [1:0]    e_cnt;
    logic [4:0]    w_fail_phase;
    logic          w_cmd_phase;
    sdi_pkg::t_res w_cmd55, w_cmd0, w_blk, w_fail;

    assign w_fail_phase = (r_phase >= sdi_pkg::P_READY) ? sdi_pkg::P_READY : sdi_pkg::P_IDLE;
    assign w_cmd_phase  = (r_phase >= sdi_pkg::P_CMD0 && r_phase <= sdi_pkg::P_ACMD41) ||
                          r_phase == sdi_pkg::P_CMD2 || r_phase == sdi_pkg::P_CMD3 ||
                          r_phase == sdi_pkg::P_CMD7 || r_phase == sdi_pkg::P_CMD16 ||
                          r_phase == sdi_pkg::P_XCMD;
    assign w_cmd55 = sdi_pkg::f_cmd(sdi_pkg::CMD_APP, sdi_pkg::K_48, 1'b1, 1'b0, 1'b0,
                                    sdi_pkg::ARG_ZERO);
    assign w_cmd0  = sdi_pkg::f_cmd(sdi_pkg::CMD_GO_IDLE, sdi_pkg::K_NONE, 1'b0, 1'b0, 1'b0,
                                    sdi_pkg::ARG_ZERO);
    // command index and direction finalized from dir_write in the datapath
    assign w_blk   = sdi_pkg::f_cmd(sdi_pkg::CMD_READ, sdi_pkg::K_48, 1'b1, 1'b1, 1'b1,
                                    sdi_pkg::ARG_BLK);
    assign w_fail  = sdi_pkg::f_act(sdi_pkg::A_FAILED);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_res0  = r_res0;
        n_res1  = r_res1;
        n_two   = r_two;
        e_cnt   = 2'd0;
        o_cmd   = '0;
        o_cmd.latch_in = i_accept;

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_res0 = '0;
                n_res1 = '0;
                unique case (i_sts.req_type)
                    sdi_pkg::E_TICK: begin
                        if (r_phase == sdi_pkg::P_CMD55 || r_phase == sdi_pkg::P_ACMD41 ||
                            r_phase == sdi_pkg::P_RETRY)
                            o_cmd.oc_op = sdi_pkg::OC_INC;
                        if (r_phase == sdi_pkg::P_SETTLE || r_phase == sdi_pkg::P_RETRY) begin
                            if (i_sts.wt_le1) begin
                                e_cnt       = 2'd1;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                                if (r_phase == sdi_pkg::P_SETTLE) begin
                                    n_res0  = w_cmd0;
                                    n_phase = sdi_pkg::P_CMD0;
                                end else begin
                                    n_res0  = w_cmd55;
                                    n_phase = sdi_pkg::P_CMD55;
                                end
                            end else begin
                                o_cmd.wt_op = sdi_pkg::WT_DEC;
                            end
                        end else if (r_phase != sdi_pkg::P_IDLE &&
                                     r_phase != sdi_pkg::P_READY) begin
                            if (!i_sts.wt_zero) begin
                                o_cmd.wt_op = sdi_pkg::WT_DEC;
                            end else if (w_cmd_phase) begin
                                e_cnt  = 2'd2;
                                n_res0 = sdi_pkg::f_act(sdi_pkg::A_RESET_CMD);
                                if (r_phase == sdi_pkg::P_CMD8) begin
                                    o_cmd.oc_op = sdi_pkg::OC_CLEAR;
                                    o_cmd.wt_op = sdi_pkg::WT_EVENT;
                                    n_res1      = w_cmd55;
                                    n_phase     = sdi_pkg::P_CMD55;
                                end else begin
                                    n_res1  = w_fail;
                                    n_phase = w_fail_phase;
                                end
                            end else begin
                                e_cnt   = 2'd1;
                                n_res0  = w_fail;
                                n_phase = w_fail_phase;
                            end
                        end
                    end
                    sdi_pkg::E_START_INIT: begin
                        o_cmd.clr_card = 1'b1;
                        o_cmd.oc_op    = sdi_pkg::OC_CLEAR;
                        e_cnt          = 2'd1;
                        if (i_sts.require_card && !i_sts.card_present) begin
                            n_phase = sdi_pkg::P_IDLE;
                            n_res0  = w_fail;
                        end else begin
                            n_res0      = sdi_pkg::f_act(sdi_pkg::A_RESET_HOST);
                            n_phase     = sdi_pkg::P_HOST_RESET;
                            o_cmd.wt_op = sdi_pkg::WT_CLOCK;
                        end
                    end
                    sdi_pkg::E_START_XFER: begin
                        if (r_phase == sdi_pkg::P_READY) begin
                            o_cmd.load_xfer = 1'b1;
                            e_cnt           = 2'd1;
                            if (i_sts.blk_zero) begin
                                n_res0 = sdi_pkg::f_act(sdi_pkg::A_OK);
                            end else begin
                                n_res0      = w_blk;
                                n_phase     = sdi_pkg::P_XCMD;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                        end else if (r_phase == sdi_pkg::P_IDLE) begin
                            e_cnt  = 2'd1;
                            n_res0 = w_fail;
                        end
                    end
                    sdi_pkg::E_CMD_DONE: begin
                        priority case (r_phase)
                            sdi_pkg::P_CMD0: begin
                                e_cnt  = 2'd1;
                                n_res0 = sdi_pkg::f_cmd(sdi_pkg::CMD_IF_COND, sdi_pkg::K_48,
                                                        1'b1, 1'b0, 1'b0, sdi_pkg::ARG_IF_COND);
                                n_phase     = sdi_pkg::P_CMD8;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                            sdi_pkg::P_CMD8: begin
                                e_cnt       = 2'd1;
                                o_cmd.oc_op = sdi_pkg::OC_CLEAR;
                                n_res0      = w_cmd55;
                                n_phase     = sdi_pkg::P_CMD55;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                            sdi_pkg::P_CMD55: begin
                                e_cnt  = 2'd1;
                                n_res0 = sdi_pkg::f_cmd(sdi_pkg::ACMD_OP_COND, sdi_pkg::K_48,
                                                        1'b0, 1'b0, 1'b0, sdi_pkg::ARG_OP_COND);
                                n_phase     = sdi_pkg::P_ACMD41;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                            sdi_pkg::P_ACMD41: begin
                                if (i_sts.resp_ready) begin
                                    e_cnt          = 2'd1;
                                    o_cmd.set_sdhc = 1'b1;
                                    n_res0 = sdi_pkg::f_cmd(sdi_pkg::CMD_ALL_CID, sdi_pkg::K_136,
                                                            1'b1, 1'b0, 1'b0, sdi_pkg::ARG_ZERO);
                                    n_phase     = sdi_pkg::P_CMD2;
                                    o_cmd.wt_op = sdi_pkg::WT_EVENT;
                                end else if (i_sts.oc_over) begin
                                    e_cnt   = 2'd1;
                                    n_res0  = w_fail;
                                    n_phase = w_fail_phase;
                                end else if (i_sts.retry_zero) begin
                                    e_cnt       = 2'd1;
                                    n_res0      = w_cmd55;
                                    n_phase     = sdi_pkg::P_CMD55;
                                    o_cmd.wt_op = sdi_pkg::WT_EVENT;
                                end else begin
                                    n_phase     = sdi_pkg::P_RETRY;
                                    o_cmd.wt_op = sdi_pkg::WT_RETRY;
                                end
                            end
                            sdi_pkg::P_CMD2: begin
                                e_cnt  = 2'd1;
                                n_res0 = sdi_pkg::f_cmd(sdi_pkg::CMD_REL_ADDR, sdi_pkg::K_48,
                                                        1'b1, 1'b0, 1'b0, sdi_pkg::ARG_ZERO);
                                n_phase     = sdi_pkg::P_CMD3;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                            sdi_pkg::P_CMD3: begin
                                e_cnt           = 2'd1;
                                o_cmd.set_rca   = 1'b1;
                                o_cmd.div_start = 1'b1;
                                o_cmd.div_sel   = 1'b1;
                                n_res0          = sdi_pkg::f_act(sdi_pkg::A_SET_CLOCK);
                                n_phase         = sdi_pkg::P_CLK_DATA;
                                o_cmd.wt_op     = sdi_pkg::WT_CLOCK;
                            end
                            sdi_pkg::P_CMD7: begin
                                e_cnt  = 2'd1;
                                n_res0 = sdi_pkg::f_cmd(sdi_pkg::CMD_BLOCKLEN, sdi_pkg::K_48,
                                                        1'b1, 1'b0, 1'b0, sdi_pkg::ARG_BLKLEN);
                                n_phase     = sdi_pkg::P_CMD16;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                            sdi_pkg::P_CMD16: begin
                                e_cnt   = 2'd1;
                                n_res0  = sdi_pkg::f_act(sdi_pkg::A_OK);
                                n_phase = sdi_pkg::P_READY;
                            end
                            sdi_pkg::P_XCMD: begin
                                n_phase     = sdi_pkg::P_XRDY;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                            default: ;
                        endcase
                    end
                    sdi_pkg::E_CMD_ERROR: begin
                        if (w_cmd_phase) begin
                            e_cnt  = 2'd2;
                            n_res0 = sdi_pkg::f_act(sdi_pkg::A_RESET_CMD);
                            if (r_phase == sdi_pkg::P_CMD8) begin
                                o_cmd.oc_op = sdi_pkg::OC_CLEAR;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                                n_res1      = w_cmd55;
                                n_phase     = sdi_pkg::P_CMD55;
                            end else begin
                                n_res1  = w_fail;
                                n_phase = w_fail_phase;
                            end
                        end else if (r_phase == sdi_pkg::P_XRDY ||
                                     r_phase == sdi_pkg::P_XDONE) begin
                            e_cnt   = 2'd1;
                            n_res0  = w_fail;
                            n_phase = w_fail_phase;
                        end
                    end
                    sdi_pkg::E_CLK_STABLE: begin
                        if (r_phase == sdi_pkg::P_CLK_ID) begin
                            n_res0 = sdi_pkg::f_act(sdi_pkg::A_POWER_ON);
                            if (i_sts.settle_zero) begin
                                e_cnt       = 2'd2;
                                n_res1      = w_cmd0;
                                n_phase     = sdi_pkg::P_CMD0;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end else begin
                                e_cnt       = 2'd1;
                                n_phase     = sdi_pkg::P_SETTLE;
                                o_cmd.wt_op = sdi_pkg::WT_SETTLE;
                            end
                        end else if (r_phase == sdi_pkg::P_CLK_DATA) begin
                            e_cnt  = 2'd1;
                            n_res0 = sdi_pkg::f_cmd(sdi_pkg::CMD_SELECT, sdi_pkg::K_48B,
                                                    1'b1, 1'b0, 1'b0, sdi_pkg::ARG_RCA);
                            n_phase     = sdi_pkg::P_CMD7;
                            o_cmd.wt_op = sdi_pkg::WT_EVENT;
                        end
                    end
                    sdi_pkg::E_DATA_READY: begin
                        if (r_phase == sdi_pkg::P_XRDY) begin
                            e_cnt       = 2'd1;
                            n_res0      = sdi_pkg::f_act(sdi_pkg::A_MOVE);
                            n_phase     = sdi_pkg::P_XDONE;
                            o_cmd.wt_op = sdi_pkg::WT_EVENT;
                        end
                    end
                    sdi_pkg::E_DATA_DONE: begin
                        if (r_phase == sdi_pkg::P_XDONE) begin
                            o_cmd.adv_block = 1'b1;
                            e_cnt           = 2'd1;
                            if (i_sts.blocks_one) begin
                                n_res0  = sdi_pkg::f_act(sdi_pkg::A_OK);
                                n_phase = sdi_pkg::P_READY;
                            end else begin
                                n_res0      = w_blk;
                                n_phase     = sdi_pkg::P_XCMD;
                                o_cmd.wt_op = sdi_pkg::WT_EVENT;
                            end
                        end
                    end
                    sdi_pkg::E_RESET_DONE: begin
                        if (r_phase == sdi_pkg::P_HOST_RESET) begin
                            e_cnt           = 2'd1;
                            o_cmd.div_start = 1'b1;
                            n_res0          = sdi_pkg::f_act(sdi_pkg::A_SET_CLOCK);
                            n_phase         = sdi_pkg::P_CLK_ID;
                            o_cmd.wt_op     = sdi_pkg::WT_CLOCK;
                        end
                    end
                    default: ;
                endcase
                n_two = (e_cnt == 2'd2);
                if (e_cnt == 2'd0)        n_state = S_IDLE;
                else if (o_cmd.div_start) n_state = S_DIV;
                else                      n_state = S_OUT0;
            end
            S_DIV: begin
                if (!i_sts.div_busy) n_state = S_OUT0;
            end
            S_OUT0: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res      = r_res0;
                    o_cmd.out_last = ~r_two;
                    n_state        = r_two ? S_OUT1 : S_IDLE;
                end
            end
            S_OUT1: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res      = r_res1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= sdi_pkg::P_IDLE;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_two   <= n_two;
        end
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

>>> hw/rtl/sd_card_init_and_block_sequencer.sv
// Top level of the SD card init and block sequencer.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    one event: req_type, resp_word, card, transfer fields
//  o_res     out  valid/ready    one host action per beat, last on final one
//  i_cfg_*   in   write enable   register index 0..7, 32-bit data
//
// One event at a time: accept, a decision state (S_EVAL), then one output state per
// result (S_OUT0, S_OUT1; up to two). A set_clock result adds the divider search
// (S_DIV), one candidate per cycle. A result waiting in the output register does not
// block the next event; further results wait for the output beat to go.
// Synchronous active-low reset returns to the idle phase with register defaults.
module sd_card_init_and_block_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    sdi_in_if.sink      i_req,
    sdi_out_if.source   o_res
);
    sdi_pkg::t_cmd w_cmd;
    sdi_pkg::t_sts w_sts;
    logic          w_ready;

    assign i_req.ready = w_ready;

    sdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (i_req.valid & w_ready),
        .i_sts      (w_sts),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd)
    );

    sdi_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req      (i_req),
        .o_res      (o_res)
    );
endmodule

>>> hw/rtl/sdi_checker.sv
// Port-level checks on the result channel, bound to the top level.
`include "assert_macros.svh"
module sdi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_action,
    input logic [5:0]  i_cmd_index,
    input logic [31:0] i_cmd_arg,
    input logic [9:0]  i_clock_div
);
    `SDI_ASSERT_NEXT(a_hold, i_valid && !i_ready, i_valid)
    `SDI_ASSERT_NOW(a_action, i_valid, i_action != sdi_pkg::A_NONE && i_action <= sdi_pkg::A_FAILED)
    `SDI_ASSERT_NOW(a_div, i_valid && i_action == sdi_pkg::A_SET_CLOCK, i_clock_div != 10'd0)
    `SDI_ASSERT_NOW(a_nodiv, i_valid && i_action != sdi_pkg::A_SET_CLOCK, i_clock_div == 10'd0)
    `SDI_ASSERT_NOW(a_nocmd, i_valid && i_action != sdi_pkg::A_ISSUE, i_cmd_index == 6'd0 && i_cmd_arg == 32'd0)
endmodule

bind sd_card_init_and_block_sequencer sdi_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_action    (o_res.action),
    .i_cmd_index (o_res.cmd_index),
    .i_cmd_arg   (o_res.cmd_arg),
    .i_clock_div (o_res.clock_div)
);

>>> test/tb_sd_card_init_and_block_sequencer.sv
// Self-checking testbench for the SD card init and block sequencer.
module tb_sd_card_init_and_block_sequencer;
    import sdi_pkg::*;

    localparam int QuietLimit = 30000;
    localparam int DrainCycles = 1100;   // room for the longest divider search

    typedef struct {
        logic [3:0]  action;
        logic [5:0]  cmd_index;
        logic [1:0]  resp_kind;
        logic        crc_check;
        logic        data_cmd;
        logic        card_to_host;
        logic [31:0] cmd_arg;
        logic [9:0]  clock_div;
        logic        card_is_sdhc;
        logic [15:0] card_rca;
        logic        last;
    } host_action_t;

    typedef struct {
        logic [3:0]  req_type;
        logic [31:0] resp_word;
        logic        card_present;
        logic        require_card;
        logic [31:0] start_lba;
        logic [15:0] block_count;
        logic        write_not_read;
        logic        typed;
        logic [3:0]  typed_action;
    } card_event_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    sdi_in_if  req_if ();
    sdi_out_if res_if ();

    sd_card_init_and_block_sequencer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    // sequencer model state
    logic [31:0] base_hz, id_hz, data_hz;
    logic [19:0] evt_to, clk_to, oc_to, retry_us, settle_us;
    logic [4:0]  phase;
    logic [19:0] wait_cnt, oc_cnt;
    logic        sdhc;
    logic [15:0] rca;
    logic [31:0] lba;
    logic [15:0] blocks_left;
    logic        dir_write;

    host_action_t expected_actions[$];
    host_action_t step_actions[$];
    card_event_t  directed_events[$];

    int fails;
    int src_idle;
    int snk_stall;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void emit(logic [3:0] act, logic [5:0] idx, logic [1:0] kind,
                                 logic crc, logic dat, logic c2h, logic [31:0] arg,
                                 logic [9:0] div);
        host_action_t a;
        if (step_actions.size() >= 2) return;
        a.action = act;
        a.cmd_index = idx;
        a.resp_kind = kind;
        a.crc_check = crc;
        a.data_cmd = dat;
        a.card_to_host = c2h;
        a.cmd_arg = arg;
        a.clock_div = div;
        a.card_is_sdhc = sdhc;
        a.card_rca = rca;
        a.last = 1'b0;
        step_actions.push_back(a);
    endfunction

    function automatic logic [9:0] clock_divider(logic [31:0] target);
        logic [63:0] b;
        logic [63:0] d;
        b = {32'd0, base_hz};
        d = 1;
        while (b / (d * 2) > {32'd0, target} && d < DivMax) d++;
        return d[9:0];
    endfunction

    function automatic void issue(logic [5:0] idx, logic [1:0] kind, logic crc, logic dat,
                                  logic c2h, logic [31:0] arg, logic [4:0] nxt);
        emit(A_ISSUE, idx, kind, crc, dat, c2h, arg, '0);
        phase = nxt;
        wait_cnt = evt_to;
    endfunction

    function automatic void fail_now();
        emit(A_FAILED, '0, K_NONE, 0, 0, 0, '0, '0);
        phase = (phase >= P_READY) ? P_READY : P_IDLE;
    endfunction

    function automatic void send_block();
        logic [31:0] arg;
        arg = sdhc ? lba : (lba << BlkShift);
        if (dir_write) issue(CMD_WRITE, K_48, 1, 1, 0, arg, P_XCMD);
        else issue(CMD_READ, K_48, 1, 1, 1, arg, P_XCMD);
    endfunction

    function automatic logic in_cmd_phase(logic [4:0] p);
        return (p >= P_CMD0 && p <= P_ACMD41) || p == P_CMD2 || p == P_CMD3 ||
               p == P_CMD7 || p == P_CMD16 || p == P_XCMD;
    endfunction

    function automatic void cmd_line_error();
        emit(A_RESET_CMD, '0, K_NONE, 0, 0, 0, '0, '0);
        if (phase == P_CMD8) begin
            // CMD8 failure is tolerated: go straight to the op-cond loop
            oc_cnt = '0;
            issue(CMD_APP, K_48, 1, 0, 0, '0, P_CMD55);
        end else begin
            fail_now();
        end
    endfunction

    function automatic void command_done(logic [31:0] resp);
        case (phase)
            P_CMD0: issue(CMD_IF_COND, K_48, 1, 0, 0, IfCondArg, P_CMD8);
            P_CMD8: begin
                oc_cnt = '0;
                issue(CMD_APP, K_48, 1, 0, 0, '0, P_CMD55);
            end
            P_CMD55: issue(ACMD_OP_COND, K_48, 0, 0, 0, OpCondArg, P_ACMD41);
            P_ACMD41: begin
                if (resp[31]) begin
                    sdhc = resp[30];
                    issue(CMD_ALL_CID, K_136, 1, 0, 0, '0, P_CMD2);
                end else if (oc_cnt > oc_to) begin
                    fail_now();
                end else if (retry_us == 0) begin
                    issue(CMD_APP, K_48, 1, 0, 0, '0, P_CMD55);
                end else begin
                    phase = P_RETRY;
                    wait_cnt = retry_us;
                end
            end
            P_CMD2: issue(CMD_REL_ADDR, K_48, 1, 0, 0, '0, P_CMD3);
            P_CMD3: begin
                rca = resp[31:16];
                emit(A_SET_CLOCK, '0, K_NONE, 0, 0, 0, '0, clock_divider(data_hz));
                phase = P_CLK_DATA;
                wait_cnt = clk_to;
            end
            P_CMD7: issue(CMD_BLOCKLEN, K_48, 1, 0, 0, BlkLenArg, P_CMD16);
            P_CMD16: begin
                emit(A_OK, '0, K_NONE, 0, 0, 0, '0, '0);
                phase = P_READY;
            end
            P_XCMD: begin
                phase = P_XRDY;
                wait_cnt = evt_to;
            end
            default: ;
        endcase
    endfunction

    // Advance the model by one accepted event and queue what it should produce.
    function automatic void predict_actions(card_event_t e);
        step_actions.delete();
        case (e.req_type)
            E_TICK: begin
                if ((phase == P_CMD55 || phase == P_ACMD41 || phase == P_RETRY) &&
                    oc_cnt != 20'hFFFFF) oc_cnt++;
                if (phase == P_SETTLE || phase == P_RETRY) begin
                    if (wait_cnt <= 1) begin
                        if (phase == P_SETTLE) issue(CMD_GO_IDLE, K_NONE, 0, 0, 0, '0, P_CMD0);
                        else issue(CMD_APP, K_48, 1, 0, 0, '0, P_CMD55);
                    end else begin
                        wait_cnt--;
                    end
                end else if (phase != P_IDLE && phase != P_READY) begin
                    if (wait_cnt == 0) begin
                        if (in_cmd_phase(phase)) cmd_line_error();
                        else fail_now();
                    end else begin
                        wait_cnt--;
                    end
                end
            end
            E_START_INIT: begin
                sdhc = 0;
                rca = '0;
                blocks_left = '0;
                oc_cnt = '0;
                if (e.require_card && !e.card_present) begin
                    phase = P_IDLE;
                    emit(A_FAILED, '0, K_NONE, 0, 0, 0, '0, '0);
                end else begin
                    emit(A_RESET_HOST, '0, K_NONE, 0, 0, 0, '0, '0);
                    phase = P_HOST_RESET;
                    wait_cnt = clk_to;
                end
            end
            E_START_XFER: begin
                if (phase == P_READY) begin
                    lba = e.start_lba;
                    blocks_left = e.block_count;
                    dir_write = e.write_not_read;
                    if (blocks_left == 0) emit(A_OK, '0, K_NONE, 0, 0, 0, '0, '0);
                    else send_block();
                end else if (phase == P_IDLE) begin
                    emit(A_FAILED, '0, K_NONE, 0, 0, 0, '0, '0);
                end
            end
            E_CMD_DONE: command_done(e.resp_word);
            E_CMD_ERROR: begin
                if (in_cmd_phase(phase)) cmd_line_error();
                else if (phase == P_XRDY || phase == P_XDONE) fail_now();
            end
            E_CLK_STABLE: begin
                if (phase == P_CLK_ID) begin
                    emit(A_POWER_ON, '0, K_NONE, 0, 0, 0, '0, '0);
                    if (settle_us == 0) begin
                        issue(CMD_GO_IDLE, K_NONE, 0, 0, 0, '0, P_CMD0);
                    end else begin
                        phase = P_SETTLE;
                        wait_cnt = settle_us;
                    end
                end else if (phase == P_CLK_DATA) begin
                    issue(CMD_SELECT, K_48B, 1, 0, 0, {rca, 16'h0000}, P_CMD7);
                end
            end
            E_DATA_READY: begin
                if (phase == P_XRDY) begin
                    emit(A_MOVE, '0, K_NONE, 0, 0, !dir_write, '0, '0);
                    phase = P_XDONE;
                    wait_cnt = evt_to;
                end
            end
            E_DATA_DONE: begin
                if (phase == P_XDONE) begin
                    blocks_left--;
                    lba++;
                    if (blocks_left == 0) begin
                        emit(A_OK, '0, K_NONE, 0, 0, 0, '0, '0);
                        phase = P_READY;
                    end else begin
                        send_block();
                    end
                end
            end
            E_RESET_DONE: begin
                if (phase == P_HOST_RESET) begin
                    emit(A_SET_CLOCK, '0, K_NONE, 0, 0, 0, '0, clock_divider(id_hz));
                    phase = P_CLK_ID;
                    wait_cnt = clk_to;
                end
            end
            default: ;
        endcase
        if (step_actions.size() > 0) begin
            step_actions[step_actions.size() - 1].last = 1'b1;
            if (e.typed) step_actions[0].action = e.typed_action;
        end
        foreach (step_actions[k]) expected_actions.push_back(step_actions[k]);
    endfunction

    function automatic void reset_model();
        base_hz = 32'd41666666;
        id_hz = 32'd400000;
        data_hz = 32'd25000000;
        evt_to = 20'd300000;
        clk_to = 20'd500000;
        oc_to = 20'd1000000;
        retry_us = 20'd10000;
        settle_us = 20'd1000;
        phase = P_IDLE;
        wait_cnt = '0;
        oc_cnt = '0;
        sdhc = 0;
        rca = '0;
        lba = '0;
        blocks_left = '0;
        dir_write = 0;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BASE:     base_hz = val;
            CFG_ID_CLK:   id_hz = val;
            CFG_DATA_CLK: data_hz = val;
            CFG_EVT_TO:   evt_to = val[19:0];
            CFG_CLK_TO:   clk_to = val[19:0];
            CFG_OC_TO:    oc_to = val[19:0];
            CFG_RETRY:    retry_us = val[19:0];
            default:      settle_us = val[19:0];
        endcase
    endtask

    task automatic send_event(card_event_t e);
        while ($urandom_range(99) < src_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= e.req_type;
        req_if.resp_word <= e.resp_word;
        req_if.card_present <= e.card_present;
        req_if.require_card <= e.require_card;
        req_if.start_lba <= e.start_lba;
        req_if.block_count <= e.block_count;
        req_if.write_not_read <= e.write_not_read;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_actions(e);
    endtask

    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic card_event_t noise_event();
        card_event_t e;
        e.req_type = $urandom_range(15);
        e.resp_word = $urandom();
        e.card_present = $urandom_range(1);
        e.require_card = $urandom_range(1);
        e.start_lba = $urandom();
        e.block_count = $urandom_range(3);
        e.write_not_read = $urandom_range(1);
        e.typed = 1'b0;
        e.typed_action = A_NONE;
        return e;
    endfunction

    // Mostly the event the card would send next, with random content.
    function automatic card_event_t next_event();
        card_event_t e;
        int r;
        e = noise_event();
        r = $urandom_range(99);
        if (r < 15) return e;
        if (r < 18) begin
            e.req_type = E_START_INIT;
            return e;
        end
        case (phase)
            P_IDLE: begin
                e.req_type = E_START_INIT;
                e.card_present = ($urandom_range(9) != 0);
            end
            P_HOST_RESET: e.req_type = (r < 24) ? E_TICK : E_RESET_DONE;
            P_CLK_ID, P_CLK_DATA: e.req_type = (r < 26) ? E_TICK : E_CLK_STABLE;
            P_SETTLE, P_RETRY: e.req_type = E_TICK;
            P_READY: begin
                e.req_type = E_START_XFER;
                if ($urandom_range(49) == 0) e.block_count = $urandom();
                else if ($urandom_range(49) == 0) e.block_count = 16'hFFFF;
                if ($urandom_range(3) == 0) e.start_lba = 32'hFFFF_FFFF - $urandom_range(2);
            end
            P_XRDY: e.req_type = (r < 24) ? E_TICK : (r < 27) ? E_CMD_ERROR : E_DATA_READY;
            P_XDONE: e.req_type = (r < 24) ? E_TICK : (r < 27) ? E_CMD_ERROR : E_DATA_DONE;
            default: begin
                e.req_type = (r < 26) ? E_TICK : (r < 30) ? E_CMD_ERROR : E_CMD_DONE;
                if (phase == P_ACMD41) e.resp_word[31] = $urandom_range(1);
            end
        endcase
        return e;
    endfunction

    task automatic add_row(logic [3:0] req, logic [31:0] resp, logic present, logic require,
                           logic [31:0] start, logic [15:0] count, logic wr,
                           logic typed, logic [3:0] act);
        card_event_t e;
        e.req_type = req;
        e.resp_word = resp;
        e.card_present = present;
        e.require_card = require;
        e.start_lba = start;
        e.block_count = count;
        e.write_not_read = wr;
        e.typed = typed;
        e.typed_action = act;
        directed_events.push_back(e);
    endtask

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_stall);
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        host_action_t x;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_actions.size() == 0) begin
                $error("unexpected beat: action %0d", res_if.action);
                fails++;
            end else begin
                x = expected_actions.pop_front();
                if (res_if.action !== x.action) begin
                    $error("action: expected %0d, got %0d", x.action, res_if.action);
                    fails++;
                end
                if (res_if.cmd_index !== x.cmd_index) begin
                    $error("cmd_index: expected %0d, got %0d", x.cmd_index, res_if.cmd_index);
                    fails++;
                end
                if (res_if.resp_kind !== x.resp_kind) begin
                    $error("resp_kind: expected %0d, got %0d", x.resp_kind, res_if.resp_kind);
                    fails++;
                end
                if (res_if.crc_check !== x.crc_check) begin
                    $error("crc_check: expected %0d, got %0d", x.crc_check, res_if.crc_check);
                    fails++;
                end
                if (res_if.data_cmd !== x.data_cmd) begin
                    $error("data_cmd: expected %0d, got %0d", x.data_cmd, res_if.data_cmd);
                    fails++;
                end
                if (res_if.card_to_host !== x.card_to_host) begin
                    $error("card_to_host: expected %0d, got %0d", x.card_to_host,
                           res_if.card_to_host);
                    fails++;
                end
                if (res_if.cmd_arg !== x.cmd_arg) begin
                    $error("cmd_arg: expected %h, got %h", x.cmd_arg, res_if.cmd_arg);
                    fails++;
                end
                if (res_if.clock_div !== x.clock_div) begin
                    $error("clock_div: expected %0d, got %0d", x.clock_div, res_if.clock_div);
                    fails++;
                end
                if (res_if.card_is_sdhc !== x.card_is_sdhc) begin
                    $error("card_is_sdhc: expected %0d, got %0d", x.card_is_sdhc,
                           res_if.card_is_sdhc);
                    fails++;
                end
                if (res_if.card_rca !== x.card_rca) begin
                    $error("card_rca: expected %h, got %h", x.card_rca, res_if.card_rca);
                    fails++;
                end
                if (res_if.last !== x.last) begin
                    $error("last: expected %0d, got %0d", x.last, res_if.last);
                    fails++;
                end
            end
        end
    end

    initial begin
        logic [31:0] hi;
        fails = 0;
        quiet_cycles = 0;
        src_idle = 0;
        snk_stall = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.resp_word = '0;
        req_if.card_present = 1'b0;
        req_if.require_card = 1'b0;
        req_if.start_lba = '0;
        req_if.block_count = '0;
        req_if.write_not_read = 1'b0;
        res_if.ready = 1'b0;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: some expected actions typed in, the rest from the model
        add_row(E_START_XFER, '0, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, A_FAILED);
        add_row(E_START_INIT, '0, 0, 1, '0, '0, 0, 1, A_FAILED);
        add_row(E_START_INIT, '0, 1, 1, '0, '0, 0, 1, A_RESET_HOST);
        add_row(E_DATA_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_RESET_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CLK_STABLE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_ERROR, '0, 0, 0, '0, '0, 0, 1, A_RESET_CMD);
        add_row(E_START_INIT, '0, 0, 0, '0, '0, 0, 1, A_RESET_HOST);
        add_row(E_RESET_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CLK_STABLE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_ERROR, '0, 0, 0, '0, '0, 0, 1, A_RESET_CMD);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, 32'h7FFF_FFFF, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, 32'hC000_0000, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, 32'hFFFF_0000, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CLK_STABLE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_START_XFER, '0, 0, 0, 32'h1234_5678, '0, 0, 1, A_OK);
        add_row(E_START_XFER, '0, 0, 0, 32'hFFFF_FFFF, 16'd2, 1, 0, A_NONE);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_DATA_READY, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_DATA_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_DONE, '0, 0, 0, '0, '0, 0, 0, A_NONE);
        add_row(E_CMD_ERROR, '0, 0, 0, '0, '0, 0, 1, A_FAILED);
        add_row(4'hF, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, A_NONE);

        // no pauses, so the directed walk needs no ticks
        write_reg(CFG_SETTLE, 32'd0);
        write_reg(CFG_RETRY, 32'd0);
        foreach (directed_events[k]) send_event(directed_events[k]);

        for (int p = 0; p < 8; p++) begin
            wait_quiet();
            case (p % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 57; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 57; end
                default: begin src_idle = 15; snk_stall = 15; end
            endcase
            hi = $urandom() & 32'hFFF0_0000;
            write_reg(CFG_BASE, (p == 1) ? 32'hFFFF_FFFF : (p == 2) ? 32'd1 :
                      $urandom_range(1000000, 200000000));
            write_reg(CFG_ID_CLK, (p == 1) ? 32'd1 : $urandom_range(100000, 2000000));
            write_reg(CFG_DATA_CLK, (p == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 60000000));
            write_reg(CFG_EVT_TO, hi | ((p == 3) ? 32'hFFFFF : $urandom_range(1, 4)));
            write_reg(CFG_CLK_TO, hi | ((p == 3) ? 32'hFFFFF : (p == 2) ? 32'd1 :
                      $urandom_range(1, 3)));
            write_reg(CFG_OC_TO, hi | ((p == 2) ? 32'd1 : (p == 3) ? 32'hFFFFF :
                      $urandom_range(1, 8)));
            write_reg(CFG_RETRY, hi | ((p == 2) ? 32'd0 : (p == 5) ? 32'hFFFFF :
                      $urandom_range(1, 3)));
            write_reg(CFG_SETTLE, hi | ((p == 2) ? 32'd0 : (p == 6) ? 32'hFFFFF :
                      $urandom_range(1, 3)));
            for (int n = 0; n < 110; n++) send_event(next_event());
        end

        wait_quiet();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
